// ----- rtl/sobel_edge_glow_hsl_defines.svh -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_GLOW_HSL_DEFINES_SVH
`define SOBEL_EDGE_GLOW_HSL_DEFINES_SVH

// same-cycle implication
`define SEGH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SEGH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/segh_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - package
// Shared constants, types and state encodings.
// ----------------------------------------------------------------------------
package segh_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int COL_W     = ADDR_W;
	localparam int ROW_W     = 12;
	localparam int PEND_W    = 12;

	localparam logic [11:0] WIDTH_MIN    = 12'd3;
	localparam logic [11:0] WIDTH_MAX    = 12'(MAX_WIDTH);
	localparam logic [12:0] HEIGHT_MIN   = 13'd3;
	localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam int DIV_W     = 25;
	localparam int DIVR_W    = 9;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [16:0] Q_ONE        = 17'd65536;
	localparam logic [16:0] Q_THIRD      = 17'd21845;
	localparam logic [16:0] Q_SIXTH      = 17'd10923;
	localparam logic [16:0] Q_HALF       = 17'd32768;
	localparam logic [16:0] Q_TWO_THIRDS = 17'd43691;
	// ceil(2^29 / 45): hue * 65536 / 360 == (hue * HUE_RECIP) >> 16 for hue < 360
	localparam logic [23:0] HUE_RECIP    = 24'd11930465;

	typedef logic [31:0] pixel_t;

	typedef enum logic [2:0] {
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT,
		CFG_THRESHOLD,
		CFG_UP_SCALE,
		CFG_REDUCE_SCALE
	} cfg_idx_t;

	typedef struct packed {
		logic [11:0] image_width;
		logic [12:0] image_height;
		logic [7:0]  threshold_level;
		logic [8:0]  up_scale;
		logic [8:0]  reduce_scale;
	} cfg_t;

	typedef struct packed {
		logic              glow;
		logic              frame_end;
		logic [8:0][31:0]  nb;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		q_entry_t entry;
	} q_wr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_st_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_RD0,
		F_RD1,
		F_EXEC,
		F_FRD,
		F_FEXEC
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SOBEL,
		B_LIGHT,
		B_HSTART,
		B_HWAIT,
		B_SSTART,
		B_SWAIT,
		B_KSTART,
		B_QMUL,
		B_PQ,
		B_CMUL,
		B_CADD,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/segh_ram.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module segh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/segh_front.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - front end
// Accepts words, keeps line stores and window, classifies each pixel as
// pass-through or glow and queues the job.
// ----------------------------------------------------------------------------
module segh_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            operation,
	input  segh_pkg::pixel_t px_in,
	input  segh_pkg::cfg_t   cfg,
	input  segh_pkg::q_st_t  q_st,
	output logic            full,
	output segh_pkg::q_wr_t  q_wr
);
	import segh_pkg::*;

	front_state_t state_q, state_d;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PEND_W-1:0] pend_q;
	pixel_t            cur_q, edge_q;
	logic [5:0][31:0]  wp_q;
	logic [ADDR_W-1:0] k_q;
	logic              kz_q;

	logic [11:0]       w_eff;
	logic [12:0]       h_eff;
	logic [12:0]       w_plus1;
	logic [ADDR_W-1:0] wlast;
	logic              accept, flush_ok, emit, border;
	logic [PEND_W-1:0] pend_cap;
	logic [11:0]       km1;
	logic [11:0]       col_next;
	logic [12:0]       row_next;

	logic [ADDR_W-1:0] up_raddr, mid_raddr;
	logic              ram_we;
	pixel_t            up_rdata, mid_rdata;

	segh_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (mid_rdata),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	segh_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (cur_q),
		.raddr (mid_raddr),
		.rdata (mid_rdata)
	);

	always_comb begin
		if (cfg.image_width < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (cfg.image_width > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = cfg.image_width;
		end
		if (cfg.image_height < HEIGHT_MIN) begin
			h_eff = HEIGHT_MIN;
		end else if (cfg.image_height > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = cfg.image_height;
		end
	end

	assign w_plus1  = {1'b0, w_eff} + 13'd1;
	assign wlast    = ADDR_W'(w_eff - 12'd1);
	assign full     = (state_q != F_IDLE) || q_st.full;
	assign accept   = push && !full;
	assign flush_ok = (pend_q != '0) && (col_q == '0) && (row_q == '0);
	assign pend_cap = ({1'b0, pend_q} > w_plus1) ? w_plus1[PEND_W-1:0] : pend_q;
	assign km1      = w_eff - pend_cap;
	assign emit     = {1'b0, pend_q} >= w_plus1;
	assign border   = (col_q == COL_W'(1)) || ({1'b0, col_q} >= w_eff)
		|| (row_q <= ROW_W'(1)) || ({1'b0, row_q} >= h_eff);
	assign col_next = {1'b0, col_q} + 12'd1;
	assign row_next = {1'b0, row_q} + 13'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		up_raddr  = wlast;
		mid_raddr = col_q;
		ram_we    = 1'b0;
		q_wr      = '0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (!operation) begin
						state_d = F_RD0;
					end else if (flush_ok) begin
						state_d = F_FRD;
					end
				end
			end
			F_RD0: begin
				state_d = F_RD1;
			end
			F_RD1: begin
				up_raddr = col_q;
				state_d  = F_EXEC;
			end
			F_EXEC: begin
				ram_we                = 1'b1;
				q_wr.push             = emit;
				q_wr.entry.frame_end  = 1'b0;
				q_wr.entry.nb         = {cur_q, wp_q[5], wp_q[4], mid_rdata, wp_q[3],
					wp_q[2], up_rdata, wp_q[1], wp_q[0]};
				if (col_q == '0) begin
					q_wr.entry.glow  = 1'b0;
					q_wr.entry.nb[4] = edge_q;
				end else if (border) begin
					q_wr.entry.glow  = 1'b0;
				end else begin
					q_wr.entry.glow  = 1'b1;
				end
				state_d = F_IDLE;
			end
			F_FRD: begin
				mid_raddr = k_q;
				state_d   = F_FEXEC;
			end
			F_FEXEC: begin
				q_wr.push            = 1'b1;
				q_wr.entry.glow      = 1'b0;
				q_wr.entry.frame_end = (pend_q == PEND_W'(1));
				q_wr.entry.nb[4]     = kz_q ? up_rdata : mid_rdata;
				state_d              = F_IDLE;
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			wp_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (!operation) begin
							if ((col_q == '0) && (row_q == '0)) begin
								pend_q <= '0;
							end
						end else if (flush_ok) begin
							pend_q <= pend_cap;
						end
					end
				end
				F_EXEC: begin
					if (!emit) begin
						pend_q <= pend_q + PEND_W'(1);
					end
					wp_q <= {cur_q, wp_q[5], mid_rdata, wp_q[3], up_rdata, wp_q[1]};
					if (col_next >= w_eff) begin
						col_q <= '0;
						row_q <= (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
					end else begin
						col_q <= col_next[COL_W-1:0];
					end
				end
				F_FEXEC: begin
					pend_q <= pend_q - PEND_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			cur_q <= px_in;
			k_q   <= km1[ADDR_W-1:0];
			kz_q  <= ({1'b0, pend_cap} == w_plus1);
		end
		if (state_q == F_RD1) begin
			edge_q <= up_rdata;
		end
	end

endmodule

// ----- rtl/segh_queue.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - job queue
// Short FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
module segh_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  segh_pkg::q_wr_t    q_wr,
	input  logic              pop,
	output segh_pkg::q_entry_t head,
	output segh_pkg::q_st_t    q_st
);
	import segh_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] rd_q, wr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign q_st.empty = (cnt_q == '0);
	assign q_st.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push    = q_wr.push && !q_st.full;
	assign do_pop     = pop && !q_st.empty;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= q_wr.entry;
		end
	end

endmodule

// ----- rtl/segh_div.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module segh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  segh_pkg::div_req_t req,
	output segh_pkg::div_rsp_t rsp
);
	import segh_pkg::*;

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0]    rem_q, dvs_q;
	logic [DIV_W-1:0]     dq_q;
	logic [DIVR_W:0]      rem_sh, rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, dq_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

endmodule

// ----- rtl/segh_back.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - back end
// Sobel magnitude, lightness update and HSL rebuild for glow jobs, one job at a time,
// into the result register.
// ----------------------------------------------------------------------------
module segh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  segh_pkg::cfg_t     cfg,
	input  segh_pkg::q_entry_t head,
	input  segh_pkg::q_st_t    q_st,
	output logic              q_pop,
	output segh_pkg::div_req_t div_req,
	input  segh_pkg::div_rsp_t div_rsp,
	input  logic              pop,
	output logic              res_valid,
	output segh_pkg::pixel_t   res_px,
	output logic              res_fe
);
	import segh_pkg::*;

	function automatic logic [7:0] sobel_mag(input logic [7:0] a0, input logic [7:0] a1,
		input logic [7:0] a2, input logic [7:0] a3, input logic [7:0] a5,
		input logic [7:0] a6, input logic [7:0] a7, input logic [7:0] a8);
		logic [11:0] gx, gy, ax, ay, m;
		gx = {4'd0, a0} + {3'd0, a1, 1'b0} + {4'd0, a2}
			- {4'd0, a6} - {3'd0, a7, 1'b0} - {4'd0, a8};
		gy = {4'd0, a2} + {3'd0, a5, 1'b0} + {4'd0, a8}
			- {4'd0, a0} - {3'd0, a3, 1'b0} - {4'd0, a6};
		ax = gx[11] ? -gx : gx;
		ay = gy[11] ? -gy : gy;
		m  = ax + ay;
		return (m > 12'd255) ? 8'd255 : m[7:0];
	endfunction

	back_state_t state_q, state_d;

	q_entry_t         job_q;
	logic [2:0][7:0]  e_q;
	logic [7:0]       mx_q, d_q;
	logic [8:0]       sum_q;
	logic [7:0]       nl_q;
	logic [8:0]       hue_q;
	logic [16:0]      s16_q, hk_q, l16_q;
	logic [34:0]      prod_q;
	logic [18:0]      qv_q, pv_q;
	logic [2:0][16:0] t_q;
	logic [1:0]       ch_q;
	logic [1:0]       reg_q;
	logic [35:0]      prod2_q;
	logic [2:0][7:0]  byte_q;
	pixel_t           fin_px_q;
	logic             fin_fe_q;
	logic             res_valid_q, res_fe_q;
	pixel_t           res_px_q;

	logic [7:0]  cr, cg, cb;
	logic [7:0]  emax, emin, el;
	logic [8:0]  el_sum;
	logic [8:0]  rs;
	logic        is_glow, is_red;
	logic [8:0]  mul_a, mul_b;
	logic [17:0] mul_p;
	logic [18:0] nl_glow;
	logic [19:0] hue_num;
	logic [8:0]  s_div;
	logic [32:0] hk_prod;
	logic [18:0] q_d, p_d, two_l;
	logic [17:0] tr_sum;
	logic [16:0] tr, tb, t_cur, fac;
	logic [38:0] six;
	logic [23:0] v;
	logic [31:0] v255;
	logic [7:0]  vb;
	logic        load_res;

	assign cr = job_q.nb[4][7:0];
	assign cg = job_q.nb[4][15:8];
	assign cb = job_q.nb[4][23:16];

	always_comb begin
		emax = e_q[0];
		emin = e_q[0];
		for (int i = 1; i < 3; i++) begin
			if (e_q[i] > emax) begin
				emax = e_q[i];
			end
			if (e_q[i] < emin) begin
				emin = e_q[i];
			end
		end
		el_sum  = {1'b0, emax} + {1'b0, emin};
		el      = el_sum[8:1];
		rs      = (cfg.reduce_scale > 9'd256) ? 9'd256 : cfg.reduce_scale;
		is_glow = el > cfg.threshold_level;
		is_red  = cfg.reduce_scale != '0;
		mul_a   = is_glow ? {el, 1'b0} : sum_q;
		mul_b   = is_glow ? cfg.up_scale : (9'd256 - rs);
		mul_p   = mul_a * mul_b;
		nl_glow = {1'b0, mul_p} + {2'b0, sum_q, 8'd0};

		if (mx_q == cr) begin
			if (cg >= cb) begin
				hue_num = 20'd60 * ({12'd0, cg} - {12'd0, cb});
			end else begin
				hue_num = 20'd360 * {12'd0, d_q} - 20'd60 * ({12'd0, cb} - {12'd0, cg});
			end
		end else if (mx_q == cg) begin
			hue_num = 20'd120 * {12'd0, d_q} + 20'd60 * {12'd0, cb} - 20'd60 * {12'd0, cr};
		end else begin
			hue_num = 20'd240 * {12'd0, d_q} + 20'd60 * {12'd0, cr} - 20'd60 * {12'd0, cg};
		end
		s_div   = (sum_q <= 9'd255) ? sum_q : (9'd510 - sum_q);
		hk_prod = {24'd0, hue_q} * {9'd0, HUE_RECIP};

		if (l16_q < Q_HALF) begin
			q_d = prod_q[34:16];
		end else begin
			q_d = {2'b0, l16_q} + {2'b0, s16_q} - prod_q[34:16];
		end
		two_l = {1'b0, l16_q, 1'b0};
		p_d   = (two_l > q_d) ? (two_l - q_d) : '0;
		if (p_d > q_d) begin
			p_d = q_d;
		end
		tr_sum = {1'b0, hk_q} + {1'b0, Q_THIRD};
		tr     = (tr_sum > {1'b0, Q_ONE}) ? 17'(tr_sum - {1'b0, Q_ONE}) : tr_sum[16:0];
		tb     = (hk_q >= Q_THIRD) ? (hk_q - Q_THIRD) : (hk_q + Q_ONE - Q_THIRD);

		t_cur = t_q[ch_q];
		fac   = (t_cur < Q_SIXTH) ? t_cur : (Q_TWO_THIRDS - t_cur);
		six   = {1'b0, prod2_q, 2'b0} + {2'b0, prod2_q, 1'b0};
		case (reg_q)
			2'd0, 2'd2: v = {5'd0, pv_q} + six[38:16] ;
			2'd1:       v = {5'd0, qv_q};
			default:    v = {5'd0, pv_q};
		endcase
		v255 = {v, 8'd0} - {8'd0, v};
		vb   = (v255[31:16] > 16'd255) ? 8'd255 : v255[23:16];
	end

	assign load_res = (state_q == B_DONE) && (!res_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		q_pop            = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {5'd0, hue_num};
		div_req.divisor  = {1'b0, d_q};
		case (state_q)
			B_IDLE: begin
				if (!q_st.empty) begin
					q_pop   = 1'b1;
					state_d = head.glow ? B_SOBEL : B_DONE;
				end
			end
			B_SOBEL: state_d = B_LIGHT;
			B_LIGHT: state_d = (is_glow || is_red) ? B_HSTART : B_DONE;
			B_HSTART: begin
				if (d_q == '0) begin
					state_d = B_KSTART;
				end else begin
					div_req.start = 1'b1;
					state_d       = B_HWAIT;
				end
			end
			B_HWAIT: state_d = div_rsp.done ? B_SSTART : B_HWAIT;
			B_SSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, d_q, 16'd0};
				div_req.divisor  = s_div;
				state_d          = B_SWAIT;
			end
			B_SWAIT: state_d = div_rsp.done ? B_KSTART : B_SWAIT;
			B_KSTART: state_d = B_QMUL;
			B_QMUL:  state_d = B_PQ;
			B_PQ:    state_d = B_CMUL;
			B_CMUL:  state_d = B_CADD;
			B_CADD:  state_d = (ch_q == 2'd2) ? B_DONE : B_CMUL;
			B_DONE: begin
				if (load_res) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q    <= head;
				fin_px_q <= head.nb[4];
				fin_fe_q <= head.frame_end;
			end
			B_SOBEL: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i] <= sobel_mag(job_q.nb[0][8*i +: 8], job_q.nb[1][8*i +: 8],
						job_q.nb[2][8*i +: 8], job_q.nb[3][8*i +: 8],
						job_q.nb[5][8*i +: 8], job_q.nb[6][8*i +: 8],
						job_q.nb[7][8*i +: 8], job_q.nb[8][8*i +: 8]);
				end
				mx_q  <= (cr >= cg) ? ((cr >= cb) ? cr : cb) : ((cg >= cb) ? cg : cb);
			end
			B_LIGHT: begin
				if (is_glow) begin
					nl_q <= (nl_glow[18:9] > 10'd255) ? 8'd255 : nl_glow[16:9];
				end else begin
					nl_q <= mul_p[16:9];
				end
			end
			B_HSTART: begin
				l16_q <= {1'b0, nl_q, 8'd0} + {9'd0, nl_q} + {16'd0, (nl_q == 8'd255)};
				hue_q <= '0;
				s16_q <= '0;
			end
			B_HWAIT: begin
				if (div_rsp.done) begin
					hue_q <= div_rsp.quot[8:0];
				end
			end
			B_SWAIT: begin
				if (div_rsp.done) begin
					s16_q <= div_rsp.quot[16:0];
				end
			end
			B_KSTART: begin
				hk_q <= hk_prod[32:16];
			end
			B_QMUL: begin
				prod_q <= l16_q * ((l16_q < Q_HALF) ? ({1'b0, Q_ONE} + {1'b0, s16_q})
					: {1'b0, s16_q});
			end
			B_PQ: begin
				qv_q <= q_d;
				pv_q <= p_d;
				t_q  <= {tb, hk_q, tr};
				ch_q <= 2'd0;
			end
			B_CMUL: begin
				prod2_q <= (qv_q - pv_q) * fac;
				if (t_cur < Q_SIXTH) begin
					reg_q <= 2'd0;
				end else if (t_cur < Q_HALF) begin
					reg_q <= 2'd1;
				end else if (t_cur < Q_TWO_THIRDS) begin
					reg_q <= 2'd2;
				end else begin
					reg_q <= 2'd3;
				end
			end
			B_CADD: begin
				byte_q[ch_q] <= vb;
				ch_q         <= ch_q + 2'd1;
				if (ch_q == 2'd2) begin
					fin_px_q <= {job_q.nb[4][31:24], vb, byte_q[1], byte_q[0]};
				end
			end
			default: begin
			end
		endcase
		if (state_q == B_SOBEL) begin
			sum_q <= {1'b0, ((cr >= cg) ? ((cr >= cb) ? cr : cb) : ((cg >= cb) ? cg : cb))}
				+ {1'b0, ((cr <= cg) ? ((cr <= cb) ? cr : cb) : ((cg <= cb) ? cg : cb))};
			d_q   <= ((cr >= cg) ? ((cr >= cb) ? cr : cb) : ((cg >= cb) ? cg : cb))
				- ((cr <= cg) ? ((cr <= cb) ? cr : cb) : ((cg <= cb) ? cg : cb));
		end
		if (load_res) begin
			res_px_q <= fin_px_q;
			res_fe_q <= fin_fe_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_px    = res_px_q;
	assign res_fe    = res_fe_q;

endmodule

// ----- rtl/sobel_edge_glow_hsl.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - top level
// Raster RGBA edge glow with 3x3 Sobel window and HSL lightness rebuild.
// ----------------------------------------------------------------------------
// Input side is a queue: a word is taken when push is high and full is low.
// operation 0 is a pixel, 1 a flush tick that drains one delayed pixel once
// the frame is complete. Results appear as a queue: the oldest result sits
// on out_* and frame_end while empty is low and is taken when pop is high.
// Registers are written through cfg_valid/cfg_ready (ready always high),
// cfg_index selecting width, height, threshold, up scale, reduce scale.
// Output lags input by image_width+1 pixels; the front end takes each pixel
// word through F_RD0, F_RD1 and F_EXEC (two line-store reads with registered
// data, one update) and each flush word through F_FRD and F_FEXEC.
// Border and pass-through pixels go from the queue straight to the result
// register; a glow pixel with nonzero chroma runs two 25-step serial divisions
// (hue and saturation) plus the hue scaling and per-channel multiply steps.
// A 4-entry job queue lets the front end keep accepting while the back end
// or a stalled receiver holds up results; full rises when the queue fills.
// Reset loads default geometry 640x480, clears counters, window and queue;
// line stores are not cleared and hold nothing useful until written.
// ----------------------------------------------------------------------------
`include "sobel_edge_glow_hsl_defines.svh"

module sobel_edge_glow_hsl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import segh_pkg::*;

	cfg_t     cfg_q;
	q_wr_t    q_wr;
	q_st_t    q_st;
	q_entry_t q_head;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     res_valid, res_fe;
	pixel_t   res_px;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= 12'd640;
			cfg_q.image_height    <= 13'd480;
			cfg_q.threshold_level <= '0;
			cfg_q.up_scale        <= '0;
			cfg_q.reduce_scale    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  cfg_q.image_width     <= cfg_data[11:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height    <= cfg_data;
				CFG_THRESHOLD:    cfg_q.threshold_level <= cfg_data[7:0];
				CFG_UP_SCALE:     cfg_q.up_scale        <= cfg_data[8:0];
				CFG_REDUCE_SCALE: cfg_q.reduce_scale    <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	segh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.operation (operation),
		.px_in     ({alpha, blue, green, red}),
		.cfg       (cfg_q),
		.q_st      (q_st),
		.full      (full),
		.q_wr      (q_wr)
	);

	segh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.head   (q_head),
		.q_st   (q_st)
	);

	segh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	segh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.q_st      (q_st),
		.q_pop     (q_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.pop       (pop && !empty),
		.res_valid (res_valid),
		.res_px    (res_px),
		.res_fe    (res_fe)
	);

	assign empty     = !res_valid;
	assign out_red   = res_px[7:0];
	assign out_green = res_px[15:8];
	assign out_blue  = res_px[23:16];
	assign out_alpha = res_px[31:24];
	assign frame_end = res_fe;

	`SEGH_ASSERT_SAME(a_q_flags, 1'b1, !(q_st.full && q_st.empty), "job queue full and empty")
	`SEGH_ASSERT_SAME(a_push_room, q_wr.push, !q_st.full, "job pushed into full queue")
	`SEGH_ASSERT_NEXT(a_busy_after_pixel, push && !full && !operation, full, "front idle after pixel")

endmodule

// ----- tb/segh_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - testbench package
// Input word codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package segh_tb_pkg;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

endpackage

// ----- tb/segh_checker.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - scoreboard
// Watches the input, result and register channels, predicts every output
// word from its own line stores and window, and compares in order.
// ----------------------------------------------------------------------------
module segh_checker
	import segh_pkg::*;
	import segh_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        operation,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_red,
	input  logic [7:0]  out_green,
	input  logic [7:0]  out_blue,
	input  logic [7:0]  out_alpha,
	input  logic        frame_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] r, g, b, a;
		logic       fe;
	} out_word_t;

	out_word_t   glow_words[$];
	cfg_t        regs;
	pixel_t      upper_mem [MAX_WIDTH];
	pixel_t      middle_mem [MAX_WIDTH];
	pixel_t      win [6];
	int unsigned col, row, pend;

	function automatic int ch(pixel_t px, int i);
		return int'(px[8*i +: 8]);
	endfunction

	function automatic logic [7:0] hsl_byte(int unsigned t, longint p, longint q);
		longint v;
		if (t < int'(Q_SIXTH)) v = p + (((q - p) * 6 * t) >>> 16);
		else if (t < int'(Q_HALF)) v = q;
		else if (t < int'(Q_TWO_THIRDS)) v = p + (((q - p) * 6 * (int'(Q_TWO_THIRDS) - t)) >>> 16);
		else v = p;
		v = (v * 255) >>> 16;
		return v > 255 ? 8'd255 : v[7:0];
	endfunction

	function automatic pixel_t glow_pixel(input pixel_t nb [9]);
		int gx, gy, mag;
		int unsigned e, emax, emin, el, nl, rr, gg, bb, mx, mn, sum, d;
		int unsigned hue, s16, l16, hk, tr, tb, rs;
		longint q, p;
		emax = 0;
		emin = 255;
		for (int i = 0; i < 3; i++) begin
			gx = ch(nb[0], i) + 2 * ch(nb[1], i) + ch(nb[2], i)
				- ch(nb[6], i) - 2 * ch(nb[7], i) - ch(nb[8], i);
			gy = ch(nb[2], i) + 2 * ch(nb[5], i) + ch(nb[8], i)
				- ch(nb[0], i) - 2 * ch(nb[3], i) - ch(nb[6], i);
			mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			e = mag > 255 ? 255 : mag;
			if (e > emax) emax = e;
			if (e < emin) emin = e;
		end
		el = (emax + emin) >> 1;
		rr = ch(nb[4], 0);
		gg = ch(nb[4], 1);
		bb = ch(nb[4], 2);
		mx = rr; if (gg > mx) mx = gg; if (bb > mx) mx = bb;
		mn = rr; if (gg < mn) mn = gg; if (bb < mn) mn = bb;
		sum = mx + mn;
		d = mx - mn;
		if (el > regs.threshold_level) begin
			nl = (2 * el * regs.up_scale + 256 * sum) >> 9;
			if (nl > 255) nl = 255;
		end else if (regs.reduce_scale != 0) begin
			rs = regs.reduce_scale > 256 ? 256 : regs.reduce_scale;
			nl = (sum * (256 - rs)) >> 9;
		end else begin
			return nb[4];
		end
		hue = 0;
		s16 = 0;
		if (d != 0) begin
			if (mx == rr) begin
				if (gg >= bb) hue = 60 * (gg - bb) / d;
				else hue = (360 * d - 60 * (bb - gg)) / d;
			end else if (mx == gg) begin
				hue = (120 * d + 60 * bb - 60 * rr) / d;
			end else begin
				hue = (240 * d + 60 * rr - 60 * gg) / d;
			end
			if (sum <= 255) s16 = (longint'(d) << 16) / sum;
			else s16 = (longint'(d) << 16) / (510 - sum);
		end
		l16 = (nl << 16) / 255;
		if (l16 < int'(Q_HALF)) q = (longint'(l16) * (65536 + s16)) >>> 16;
		else q = longint'(l16) + s16 - ((longint'(l16) * s16) >>> 16);
		p = 2 * longint'(l16);
		p = p > q ? p - q : 0;
		if (p > q) p = q;
		hk = (hue << 16) / 360;
		tr = hk + int'(Q_THIRD);
		if (tr > int'(Q_ONE)) tr -= int'(Q_ONE);
		tb = hk >= int'(Q_THIRD) ? hk - int'(Q_THIRD) : hk + int'(Q_ONE) - int'(Q_THIRD);
		return {nb[4][31:24], hsl_byte(tb, p, q), hsl_byte(hk, p, q), hsl_byte(tr, p, q)};
	endfunction

	task automatic queue_word(pixel_t px, logic fe);
		out_word_t w;
		w.r = px[7:0];
		w.g = px[15:8];
		w.b = px[23:16];
		w.a = px[31:24];
		w.fe = fe;
		glow_words.push_back(w);
	endtask

	task automatic take_word(logic op, pixel_t cur);
		int unsigned w, h, c, r, k;
		pixel_t u, m, px;
		pixel_t nb [9];
		w = regs.image_width < 3 ? 3 : (regs.image_width > MAX_WIDTH ? MAX_WIDTH : regs.image_width);
		h = regs.image_height < 3 ? 3 : (regs.image_height > 4096 ? 4096 : regs.image_height);
		c = col;
		r = row;
		if (op == OP_FLUSH) begin
			if (pend == 0 || c != 0 || r != 0) return;
			if (pend > w + 1) pend = w + 1;
			k = w + 1 - pend;
			px = k == 0 ? upper_mem[w - 1] : middle_mem[k - 1];
			pend--;
			queue_word(px, pend == 0);
			return;
		end
		if (c == 0 && r == 0) pend = 0;
		if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
		u = upper_mem[c];
		m = middle_mem[c];
		if (pend >= w + 1) begin
			if (c == 0) begin
				px = upper_mem[w - 1];
			end else if (c == 1 || c >= w || r <= 1 || r >= h) begin
				px = win[3];
			end else begin
				nb = '{win[0], win[1], u, win[2], win[3], m, win[4], win[5], cur};
				px = glow_pixel(nb);
			end
			queue_word(px, 1'b0);
		end else begin
			pend++;
		end
		upper_mem[c] = m;
		middle_mem[c] = cur;
		win = '{win[1], u, win[3], m, win[5], cur};
		if (c + 1 >= w) begin
			col = 0;
			row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col = c + 1;
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			regs = '{image_width: 12'd640, image_height: 13'd480, default: '0};
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_mem[i] = '0;
				middle_mem[i] = '0;
			end
			win = '{default: '0};
			col = 0;
			row = 0;
			pend = 0;
			glow_words.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty) begin
				if (glow_words.size() == 0) begin
					report_mismatch("unexpected word", out_red, -1);
				end else begin
					want = glow_words.pop_front();
					if (out_red != want.r) report_mismatch("out_red", out_red, want.r);
					if (out_green != want.g) report_mismatch("out_green", out_green, want.g);
					if (out_blue != want.b) report_mismatch("out_blue", out_blue, want.b);
					if (out_alpha != want.a) report_mismatch("out_alpha", out_alpha, want.a);
					if (frame_end != want.fe) report_mismatch("frame_end", frame_end, want.fe);
				end
			end
			if (push && !full)
				take_word(operation, {alpha, blue, green, red});
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_IMAGE_WIDTH: regs.image_width = cfg_data[11:0];
					CFG_IMAGE_HEIGHT: regs.image_height = cfg_data;
					CFG_THRESHOLD: regs.threshold_level = cfg_data[7:0];
					CFG_UP_SCALE: regs.up_scale = cfg_data[8:0];
					CFG_REDUCE_SCALE: regs.reduce_scale = cfg_data[8:0];
					default: ;
				endcase
			end
			outstanding = glow_words.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Sobel edge glow (HSL) - testbench top
// Drives frames of random and patterned pixels under varying geometry and
// glow settings, with flush drains, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb;
	import segh_pkg::*;
	import segh_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE = 600;
	localparam int LIMIT  = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        operation = OP_PIXEL;
	logic [7:0]  red = '0, green = '0, blue = '0, alpha = '0;
	logic        pop = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        full, empty, cfg_ready, frame_end;
	logic [7:0]  out_red, out_green, out_blue, out_alpha;
	int          mismatches, outstanding;
	int          cycles = 0;
	int          words_sent = 0;
	bit          steady = 1'b0;

	sobel_edge_glow_hsl uut (.*);
	segh_checker chk (.*);

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("sobel_edge_glow_hsl regression: fail");
			$finish;
		end
	end

	always @(posedge clk) pop <= steady || ($urandom_range(99) >= 9);

	task automatic send_word(logic op, logic [7:0] r, g, b, a);
		bit ok;
		if (!steady && $urandom_range(99) < 9) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		alpha <= a;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		words_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 13'(value);
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(int w, int h, int thr, int up, int rs);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_UP_SCALE, up);
		write_reg(CFG_REDUCE_SCALE, rs);
	endtask

	// mode 0 random, 1 flat, 2 stripes, 3 gray, 4 noise around base
	task automatic send_frame(int w, int rows, int mode, bit retune);
		logic [7:0] br, bg, bb, v;
		int col;
		br = 8'($urandom);
		bg = 8'($urandom);
		bb = 8'($urandom);
		for (int n = 0; n < w * rows; n++) begin
			col = n % w;
			if (retune && n == 2 * w) begin
				drain();
				write_reg(CFG_THRESHOLD, $urandom_range(255));
				write_reg(CFG_REDUCE_SCALE, $urandom_range(511));
			end
			case (mode)
				0: send_word(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
				1: send_word(OP_PIXEL, br, bg, bb, 8'($urandom));
				2: send_word(OP_PIXEL, col[0] ? br : 8'd0, col[1] ? bg : 8'd255,
					bb ^ {8{col[0]}}, 8'($urandom));
				3: begin
					v = 8'($urandom);
					send_word(OP_PIXEL, v, v, v, 8'($urandom));
				end
				default: send_word(OP_PIXEL, 8'(br + $urandom_range(15)),
					8'(bg + $urandom_range(15)), 8'(bb + $urandom_range(15)),
					8'($urandom));
			endcase
		end
	endtask

	task automatic flush_frame(int w);
		for (int n = 0; n < w + 2; n++)
			send_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	function automatic int pick(int a, int b, int c);
		case ($urandom_range(3))
			0: return a;
			1: return b;
			2: return c;
			default: return $urandom_range(c);
		endcase
	endfunction

	initial begin
		int w, h, phase;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 4x3 frame of extremes, height written as 0 (clamps to 3)
		setup(4, 0, 0, 256, 128);
		send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
		send_word(OP_PIXEL, 8'd255, 8'd0, 8'd0, 8'd255);
		send_word(OP_PIXEL, 8'd0, 8'd255, 8'd0, 8'd1);
		send_word(OP_PIXEL, 8'd0, 8'd0, 8'd255, 8'd128);
		send_word(OP_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0);  // mid-frame: ignored
		send_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255);
		send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(OP_PIXEL, 8'd255, 8'd128, 8'd0, 8'd7);
		send_word(OP_PIXEL, 8'd10, 8'd200, 8'd90, 8'd254);
		send_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
		send_word(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
		send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
		flush_frame(4);  // last flush finds nothing pending
		drain();

		// tall height clamps to 4096, then shrinks mid-frame to end the frame
		setup(5, 8191, 255, 511, 0);
		send_frame(5, 4, 0, 1'b0);
		drain();
		write_reg(CFG_IMAGE_HEIGHT, 3);
		send_frame(5, 1, 0, 1'b0);
		flush_frame(5);
		drain();

		phase = 0;
		while (words_sent < 1550) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(3, 24) : $urandom_range(3, 10);
			h = $urandom_range(3, 5);
			steady = (phase >= 4 && phase < 12);
			setup(($urandom_range(7) == 0) ? $urandom_range(2) : w, h,
				pick(0, 255, 255), pick(0, 256, 511), pick(0, 256, 511));
			if ($urandom_range(7) == 0) w = 3;
			send_frame(w, h, $urandom_range(4), $urandom_range(5) == 0);
			if ($urandom_range(9) != 0) flush_frame(w);
			drain();
			phase++;
		end
		steady = 1'b0;

		// widest geometry, width written as all ones; a partial first row
		setup(4095, 3, 40, 300, 64);
		for (int n = 0; n < 200; n++)
			send_word(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("sobel_edge_glow_hsl regression: pass");
		else
			$display("sobel_edge_glow_hsl regression: fail");
		$finish;
	end

endmodule
